[rtl/slc_pkg.sv]
// shared types and constants for the split l1 cache tag controller
// no dependencies
package slc_pkg;

  typedef enum logic [2:0] {
    OP_DREAD  = 3'd0,
    OP_DWRITE = 3'd1,
    OP_IFETCH = 3'd2,
    OP_SNINV  = 3'd3,
    OP_RFO    = 3'd4,
    OP_CLEAR  = 3'd5
  } op_t;

  localparam logic [1:0] ST_M = 2'd0;
  localparam logic [1:0] ST_E = 2'd1;
  localparam logic [1:0] ST_S = 2'd2;
  localparam logic [1:0] ST_I = 2'd3;

  localparam logic [1:0] MSG_NONE = 2'd0;
  localparam logic [1:0] MSG_READ = 2'd1;
  localparam logic [1:0] MSG_RFO  = 2'd2;
  localparam logic [1:0] MSG_RET  = 2'd3;

endpackage

[rtl/slc_if.sv]
// valid/ready channel interfaces for request and result words
// depends on nothing
interface slc_req_if;
  logic        valid;
  logic        ready;
  logic [2:0]  op;
  logic [31:0] address;
  modport source (output valid, op, address, input ready);
  modport sink (input valid, op, address, output ready);
endinterface

interface slc_rsp_if;
  logic        valid;
  logic        ready;
  logic        hit;
  logic [1:0]  l2_message;
  logic        writeback;
  logic [31:0] writeback_address;
  logic [1:0]  line_state;
  modport source (output valid, hit, l2_message, writeback, writeback_address, line_state,
                  input ready);
  modport sink (input valid, hit, l2_message, writeback, writeback_address, line_state,
                output ready);
endinterface

[rtl/split_l1_cache_mesi_lru.sv]
// split l1 cache tag controller: mesi states, counter lru, one set per access
// a request passes set read, a way walk, decide and row write before its result is valid;
// a new word is taken only after the previous result is accepted, and the shared tag compare
// unit walks one way per cycle
// clear all sweeps NUM_SETS sets one per cycle, result valid after the sweep
// reset: a clearing pass over all NUM_SETS sets runs after rst, request ready stays low
module split_l1_cache_mesi_lru #(
  parameter int NUM_SETS   = 16384,
  parameter int DATA_WAYS  = 8,
  parameter int INSTR_WAYS = 4,
  parameter int LINE_BYTES = 64
) (
  input logic clk,
  input logic rst,
  slc_req_if.sink   req,
  slc_rsp_if.source rsp
);

  localparam int OFFW = $clog2(LINE_BYTES);
  localparam int IDXW = $clog2(NUM_SETS);
  localparam int TAGW = 32 - OFFW - IDXW;
  localparam int MAXW = (DATA_WAYS > INSTR_WAYS) ? DATA_WAYS : INSTR_WAYS;
  localparam int WW   = $clog2(MAXW);
  localparam int WCW  = $clog2(MAXW + 1);

  typedef struct packed {
    logic            valid;
    logic [TAGW-1:0] tag;
    logic [1:0]      mesi;
    logic [WW-1:0]   rank;
    logic [OFFW-1:0] offset;
  } way_t;

  typedef enum logic [6:0] {
    S_CLR  = 7'b0000001,
    S_IDLE = 7'b0000010,
    S_RD   = 7'b0000100,
    S_SCAN = 7'b0001000,
    S_DEC  = 7'b0010000,
    S_UPD  = 7'b0100000,
    S_OUT  = 7'b1000000
  } state_t;

  // one row per set, all ways of the set in one word
  way_t dmem [NUM_SETS][DATA_WAYS];
  way_t imem [NUM_SETS][INSTR_WAYS];
  way_t drow [DATA_WAYS];
  way_t irow [INSTR_WAYS];
  way_t row [MAXW];
  way_t row_next [MAXW];
  way_t row_load [MAXW];

  state_t state, state_next;
  logic [IDXW:0]   clr_cnt;
  logic            clr_req;
  logic [2:0]      op;
  logic [TAGW-1:0] tag;
  logic [IDXW-1:0] idx;
  logic [IDXW-1:0] rd_idx;
  logic [OFFW-1:0] off;
  logic            is_i;
  logic [WCW-1:0]  cnt;
  logic            found, found_m, found_inv, found_r0;
  logic [WW-1:0]   fw, mw, iw, rw;
  logic            o_hit, o_wb;
  logic [1:0]      o_msg, o_st;
  logic [31:0]     o_wba;
  logic            r_hit, r_wb;
  logic [1:0]      r_msg, r_st;
  logic [31:0]     r_wba;
  logic            mem_we;
  logic [WCW-1:0]  ways;

  assign ways = is_i ? WCW'(INSTR_WAYS) : WCW'(DATA_WAYS);
  assign req.ready = (state == S_IDLE);
  assign rsp.valid = (state == S_OUT);
  assign rsp.hit = r_hit;
  assign rsp.l2_message = r_msg;
  assign rsp.writeback = r_wb;
  assign rsp.writeback_address = r_wba;
  assign rsp.line_state = r_st;

  // the set is read at the accept edge so the row is ready in S_RD
  assign rd_idx = (state == S_IDLE) ? req.address[OFFW +: IDXW] : idx;

  always_ff @(posedge clk) begin
    for (int w = 0; w < DATA_WAYS; w++) begin
      if (state == S_CLR)
        dmem[clr_cnt[IDXW-1:0]][w] <= '{1'b0, '0, slc_pkg::ST_I, WW'(w), '0};
      else if (mem_we && !is_i)
        dmem[idx][w] <= row[w];
      drow[w] <= dmem[rd_idx][w];
    end
    for (int w = 0; w < INSTR_WAYS; w++) begin
      if (state == S_CLR)
        imem[clr_cnt[IDXW-1:0]][w] <= '{1'b0, '0, slc_pkg::ST_I, WW'(w), '0};
      else if (mem_we && is_i)
        imem[idx][w] <= row[w];
      irow[w] <= imem[rd_idx][w];
    end
  end

  assign mem_we = (state == S_UPD);

  always_comb begin
    for (int w = 0; w < MAXW; w++) row_load[w] = '0;
    if (is_i) begin
      for (int w = 0; w < INSTR_WAYS; w++) row_load[w] = irow[w];
    end else begin
      for (int w = 0; w < DATA_WAYS; w++) row_load[w] = drow[w];
    end
  end

  // decide: touch and state update on the working row
  logic [WW-1:0] tw, oldr;
  logic          dotouch;
  always_comb begin
    for (int w = 0; w < MAXW; w++) row_next[w] = row[w];
    o_hit = 1'b0; o_msg = slc_pkg::MSG_NONE; o_wb = 1'b0; o_st = slc_pkg::ST_I; o_wba = '0;
    tw = '0; dotouch = 1'b0;
    if (op == slc_pkg::OP_SNINV) begin
      for (int w = 0; w < DATA_WAYS; w++)
        if (row[w].valid && row[w].tag == tag) begin
          row_next[w].valid = 1'b0; row_next[w].mesi = slc_pkg::ST_I; o_hit = 1'b1;
        end
    end else if (op == slc_pkg::OP_RFO && found_m) begin
      row_next[mw].valid = 1'b0; row_next[mw].mesi = slc_pkg::ST_I;
      o_hit = 1'b1; o_msg = slc_pkg::MSG_RET;
    end else if (op == slc_pkg::OP_DREAD || op == slc_pkg::OP_DWRITE ||
                 op == slc_pkg::OP_IFETCH || op == slc_pkg::OP_RFO) begin
      dotouch = 1'b1;
      if (found) begin
        tw = fw; o_hit = 1'b1;
        if (op == slc_pkg::OP_DWRITE) row_next[fw].mesi = slc_pkg::ST_M;
        else if (row[fw].mesi == slc_pkg::ST_E) row_next[fw].mesi = slc_pkg::ST_S;
        else if (row[fw].mesi == slc_pkg::ST_I) row_next[fw].mesi = slc_pkg::ST_E;
        o_st = row_next[fw].mesi;
      end else begin
        tw = found_inv ? iw : (found_r0 ? rw : '0);
        if (row[tw].valid && row[tw].mesi == slc_pkg::ST_M) begin
          o_wb = 1'b1;
          o_wba = {row[tw].tag, idx, row[tw].offset};
        end
        row_next[tw].valid = 1'b1; row_next[tw].tag = tag; row_next[tw].offset = off;
        row_next[tw].mesi = (op == slc_pkg::OP_DWRITE) ? slc_pkg::ST_M : slc_pkg::ST_E;
        o_msg = (op == slc_pkg::OP_DWRITE) ? slc_pkg::MSG_RFO : slc_pkg::MSG_READ;
        o_st = row_next[tw].mesi;
      end
    end
    oldr = row[tw].rank;
    if (dotouch) begin
      for (int w = 0; w < MAXW; w++)
        if (WCW'(w) < ways && row[w].rank > oldr) row_next[w].rank = row[w].rank - 1'b1;
      row_next[tw].rank = WW'(ways - 1'b1);
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_CLR:  if (clr_cnt == (IDXW+1)'(NUM_SETS - 1)) state_next = clr_req ? S_OUT : S_IDLE;
      S_IDLE: if (req.valid) begin
        if (req.op == slc_pkg::OP_CLEAR) state_next = S_CLR;
        else state_next = S_RD;
      end
      S_RD:   state_next = S_SCAN;
      S_SCAN: if (cnt == ways - 1'b1) state_next = S_DEC;
      S_DEC:  state_next = S_UPD;
      S_UPD:  state_next = S_OUT;
      S_OUT:  if (rsp.ready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_CLR;
      clr_cnt <= '0;
      clr_req <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_CLR) clr_cnt <= clr_cnt + 1'b1;
      else clr_cnt <= '0;
      if (state == S_IDLE && req.valid) clr_req <= (req.op == slc_pkg::OP_CLEAR);
    end
    if (state == S_IDLE && req.valid) begin
      op   <= req.op;
      off  <= req.address[OFFW-1:0];
      idx  <= req.address[OFFW +: IDXW];
      tag  <= req.address[31 -: TAGW];
      is_i <= (req.op == slc_pkg::OP_IFETCH);
      // clear and unused ops give the default word
      r_hit <= 1'b0; r_msg <= slc_pkg::MSG_NONE; r_wb <= 1'b0; r_wba <= '0;
      r_st <= slc_pkg::ST_I;
    end
    if (state == S_RD) begin
      for (int w = 0; w < MAXW; w++) row[w] <= row_load[w];
      cnt <= '0;
      found <= 1'b0; found_m <= 1'b0; found_inv <= 1'b0; found_r0 <= 1'b0;
      fw <= '0; mw <= '0; iw <= '0; rw <= '0;
    end
    // shared compare unit, one way per cycle, first match wins
    if (state == S_SCAN) begin
      cnt <= cnt + 1'b1;
      if (!found && row[cnt[WW-1:0]].valid && row[cnt[WW-1:0]].tag == tag) begin
        found <= 1'b1; fw <= cnt[WW-1:0];
      end
      if (!found_m && row[cnt[WW-1:0]].valid && row[cnt[WW-1:0]].tag == tag &&
          row[cnt[WW-1:0]].mesi == slc_pkg::ST_M) begin
        found_m <= 1'b1; mw <= cnt[WW-1:0];
      end
      if (!found_inv && !row[cnt[WW-1:0]].valid) begin
        found_inv <= 1'b1; iw <= cnt[WW-1:0];
      end
      if (!found_r0 && row[cnt[WW-1:0]].rank == '0) begin
        found_r0 <= 1'b1; rw <= cnt[WW-1:0];
      end
    end
    if (state == S_DEC) begin
      for (int w = 0; w < MAXW; w++) row[w] <= row_next[w];
      if (op == slc_pkg::OP_DREAD || op == slc_pkg::OP_DWRITE || op == slc_pkg::OP_IFETCH ||
          op == slc_pkg::OP_RFO || op == slc_pkg::OP_SNINV) begin
        r_hit <= o_hit; r_msg <= o_msg; r_wb <= o_wb; r_wba <= o_wba; r_st <= o_st;
      end
    end
  end

endmodule

[sim/tb_split_l1_cache_mesi_lru.sv]
// testbench for the split l1 cache tag controller: random and directed words,
// predicted mesi/lru results compared in order; depends on slc_pkg, slc_if and the rtl
`timescale 1ns / 1ps
module tb_split_l1_cache_mesi_lru;

  localparam int NSETS = 16384;
  localparam int DWAYS = 8;
  localparam int IWAYS = 4;
  localparam int LBYTES = 64;
  localparam int OFF_W = 6;
  localparam int IDX_W = 14;
  localparam int WATCHDOG = 200000;
  localparam logic [2:0] OP_RSV6 = 3'd6;
  localparam logic [2:0] OP_RSV7 = 3'd7;

  typedef struct packed {
    logic [2:0]  op;
    logic [31:0] address;
  } req_t;

  typedef struct packed {
    logic        hit;
    logic [1:0]  l2_message;
    logic        writeback;
    logic [31:0] writeback_address;
    logic [1:0]  line_state;
  } rsp_t;

  typedef struct {
    bit          valid;
    logic [11:0] tag;
    logic [1:0]  mesi;
    logic [3:0]  rank;
    logic [5:0]  offset;
  } way_t;

  logic clk = 0;
  logic rst = 1;
  always #5 clk = ~clk;

  slc_req_if req ();
  slc_rsp_if rsp ();

  split_l1_cache_mesi_lru dut (.clk(clk), .rst(rst), .req(req), .rsp(rsp));

  way_t dstore [NSETS][DWAYS];
  way_t istore [NSETS][IWAYS];
  // only sets that were touched since the last clear are kept, others read as reset
  bit   dlive [int];
  bit   ilive [int];

  req_t pending_words[$];
  rsp_t expected_rsp[$];
  int   errors = 0;
  int   idle_cycles = 0;
  bit   req_acc = 0;

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    errors++;
    $display("mismatch %s: got %h expected %h", what, got, want);
  endtask

  function automatic void wake_set(input bit is_data, input int idx);
    if (is_data && !dlive.exists(idx)) begin
      for (int w = 0; w < DWAYS; w++) dstore[idx][w] = '{0, 0, slc_pkg::ST_I, w[3:0], 0};
      dlive[idx] = 1;
    end
    if (!is_data && !ilive.exists(idx)) begin
      for (int w = 0; w < IWAYS; w++) istore[idx][w] = '{0, 0, slc_pkg::ST_I, w[3:0], 0};
      ilive[idx] = 1;
    end
  endfunction

  // runs one access on a copy of a set; returns the updated set through ref
  function automatic void access_set(ref way_t s[16], input int nways, input int idx,
                                     input logic [11:0] tag, input logic [5:0] offset,
                                     input bit wr_mode, inout rsp_t r);
    int f;
    int v;
    logic [3:0] old;
    f = -1;
    for (int i = 0; i < nways; i++)
      if (f < 0 && s[i].valid && s[i].tag == tag) f = i;
    if (f >= 0) begin
      if (wr_mode) s[f].mesi = slc_pkg::ST_M;
      else if (s[f].mesi == slc_pkg::ST_E) s[f].mesi = slc_pkg::ST_S;
      else if (s[f].mesi == slc_pkg::ST_I) s[f].mesi = slc_pkg::ST_E;
      r.hit = 1;
      v = f;
    end else begin
      v = -1;
      for (int i = 0; i < nways; i++) if (v < 0 && !s[i].valid) v = i;
      for (int i = 0; i < nways; i++) if (v < 0 && s[i].rank == 0) v = i;
      if (v < 0) v = 0;
      if (s[v].valid && s[v].mesi == slc_pkg::ST_M) begin
        r.writeback = 1;
        r.writeback_address = {s[v].tag, idx[IDX_W-1:0], s[v].offset};
      end
      s[v].valid = 1;
      s[v].tag = tag;
      s[v].offset = offset;
      s[v].mesi = wr_mode ? slc_pkg::ST_M : slc_pkg::ST_E;
      r.l2_message = wr_mode ? slc_pkg::MSG_RFO : slc_pkg::MSG_READ;
    end
    old = s[v].rank;
    for (int i = 0; i < nways; i++) if (s[i].rank > old) s[i].rank--;
    s[v].rank = 4'(nways - 1);
    r.line_state = s[v].mesi;
  endfunction

  function automatic rsp_t predict_lookup(input req_t w);
    rsp_t r;
    way_t s[16];
    int idx;
    logic [11:0] tag;
    bit done;
    r = '{0, slc_pkg::MSG_NONE, 0, 32'd0, slc_pkg::ST_I};
    idx = int'(w.address[OFF_W +: IDX_W]);
    tag = w.address[31 -: 12];
    done = 0;
    case (w.op) inside
      slc_pkg::OP_DREAD, slc_pkg::OP_DWRITE, slc_pkg::OP_SNINV, slc_pkg::OP_RFO: begin
        wake_set(1, idx);
        for (int i = 0; i < DWAYS; i++) s[i] = dstore[idx][i];
        if (w.op == slc_pkg::OP_SNINV) begin
          for (int i = 0; i < DWAYS; i++)
            if (s[i].valid && s[i].tag == tag) begin
              s[i].valid = 0;
              s[i].mesi = slc_pkg::ST_I;
              r.hit = 1;
            end
        end else if (w.op == slc_pkg::OP_RFO) begin
          for (int i = 0; i < DWAYS; i++)
            if (!done && s[i].valid && s[i].tag == tag && s[i].mesi == slc_pkg::ST_M) begin
              s[i].valid = 0;
              s[i].mesi = slc_pkg::ST_I;
              r.hit = 1;
              r.l2_message = slc_pkg::MSG_RET;
              done = 1;
            end
          if (!done) access_set(s, DWAYS, idx, tag, w.address[OFF_W-1:0], 0, r);
        end else begin
          access_set(s, DWAYS, idx, tag, w.address[OFF_W-1:0],
                     w.op == slc_pkg::OP_DWRITE, r);
        end
        for (int i = 0; i < DWAYS; i++) dstore[idx][i] = s[i];
      end
      slc_pkg::OP_IFETCH: begin
        wake_set(0, idx);
        for (int i = 0; i < IWAYS; i++) s[i] = istore[idx][i];
        access_set(s, IWAYS, idx, tag, w.address[OFF_W-1:0], 0, r);
        for (int i = 0; i < IWAYS; i++) istore[idx][i] = s[i];
      end
      slc_pkg::OP_CLEAR: begin
        dlive.delete();
        ilive.delete();
      end
      default: ;
    endcase
    return r;
  endfunction

  // request taken at the last rising edge
  always @(posedge clk) req_acc <= !rst && req.valid && req.ready;

  // driver
  int send_gap = 0;
  always @(negedge clk) begin
    if (rst) begin
      req.valid <= 0;
      req.op <= '0;
      req.address <= '0;
    end else if (req.valid && !req_acc) begin
      // hold the word
    end else if (send_gap > 0) begin
      send_gap <= send_gap - 1;
      req.valid <= 0;
    end else if (pending_words.size() > 0) begin
      req.valid <= 1;
      req.op <= pending_words[0].op;
      req.address <= pending_words[0].address;
      void'(pending_words.pop_front());
      send_gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14);
    end else begin
      req.valid <= 0;
    end
  end

  // receiver stall
  int recv_gap = 0;
  always @(negedge clk) begin
    if (rst) begin
      rsp.ready <= 0;
    end else if (recv_gap > 0) begin
      recv_gap <= recv_gap - 1;
      rsp.ready <= 0;
    end else if (rsp.ready && rsp.valid) begin
      rsp.ready <= 0;
      recv_gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14);
    end else begin
      rsp.ready <= 1;
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst) begin
      if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (req.valid && req.ready) begin
        expected_rsp.push_back(predict_lookup('{req.op, req.address}));
      end
      if (rsp.valid && rsp.ready) begin
        if (expected_rsp.size() == 0) begin
          report("unexpected word", 0, 0);
        end else begin
          rsp_t e;
          e = expected_rsp.pop_front();
          if (rsp.hit !== e.hit) report("hit", 32'(rsp.hit), 32'(e.hit));
          if (rsp.l2_message !== e.l2_message)
            report("l2_message", 32'(rsp.l2_message), 32'(e.l2_message));
          if (rsp.writeback !== e.writeback)
            report("writeback", 32'(rsp.writeback), 32'(e.writeback));
          if (rsp.writeback_address !== e.writeback_address)
            report("writeback_address", rsp.writeback_address, e.writeback_address);
          if (rsp.line_state !== e.line_state)
            report("line_state", 32'(rsp.line_state), 32'(e.line_state));
        end
      end
      if (idle_cycles >= WATCHDOG) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  function automatic logic [31:0] mk_addr(input logic [11:0] tag, input int idx);
    return {tag, idx[IDX_W-1:0], 6'($urandom_range(0, LBYTES - 1))};
  endfunction

  task automatic push_word(input logic [2:0] op, input logic [31:0] a);
    pending_words.push_back('{op, a});
  endtask

  task automatic drain;
    wait (pending_words.size() == 0 && !req.valid);
    wait (expected_rsp.size() == 0);
    repeat (30) @(posedge clk);
  endtask

  initial begin
    int idx;
    int r;
    logic [2:0] op;
    repeat (11) @(posedge clk);
    rst <= 0;

    // directed: address extremes, every op, eviction of modified line, rfo both ways
    push_word(slc_pkg::OP_DREAD, 32'h0000_0000);
    push_word(slc_pkg::OP_DREAD, 32'h0000_0000);
    push_word(slc_pkg::OP_DREAD, 32'hFFFF_FFFF);
    push_word(slc_pkg::OP_DWRITE, 32'hFFFF_FFFF);
    push_word(slc_pkg::OP_IFETCH, 32'hFFFF_FFFF);
    push_word(slc_pkg::OP_IFETCH, 32'h0000_0000);
    for (int t = 1; t <= 9; t++) push_word(slc_pkg::OP_DWRITE, {12'(t), 14'd5, 6'(t * 7)});
    push_word(slc_pkg::OP_RFO, {12'd9, 14'd5, 6'd0});
    push_word(slc_pkg::OP_RFO, {12'd9, 14'd5, 6'd0});
    push_word(slc_pkg::OP_SNINV, {12'd8, 14'd5, 6'd0});
    push_word(slc_pkg::OP_SNINV, {12'd8, 14'd5, 6'd0});
    push_word(OP_RSV6, 32'h1234_5678);
    push_word(OP_RSV7, 32'hFFFF_FFFF);
    push_word(slc_pkg::OP_CLEAR, 32'h0);
    push_word(slc_pkg::OP_DREAD, {12'd9, 14'd5, 6'd0});
    // pause until every result is back
    drain();

    // random: few sets and tags so lines collide, evict and hit
    for (int n = 0; n < 450; n++) begin
      r = $urandom_range(0, 99);
      idx = (r < 90) ? $urandom_range(0, 3) : $urandom_range(0, NSETS - 1);
      if (r < 30) op = slc_pkg::OP_DREAD;
      else if (r < 55) op = slc_pkg::OP_DWRITE;
      else if (r < 72) op = slc_pkg::OP_IFETCH;
      else if (r < 82) op = slc_pkg::OP_SNINV;
      else if (r < 95) op = slc_pkg::OP_RFO;
      else if (r < 97) op = slc_pkg::OP_CLEAR;
      else op = ($urandom_range(0, 1) == 0) ? OP_RSV6 : OP_RSV7;
      if (r % 10 == 0) push_word(op, $urandom);
      else push_word(op, mk_addr(12'($urandom_range(0, 11)) ^ {12{r[0]}}, idx));
      if (n == 225) begin
        wait (pending_words.size() == 0);
        drain();
      end
    end
    drain();
    repeat (50) @(posedge clk);
    if (errors == 0 && expected_rsp.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule
